/* hw/rtl/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the keyed set table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned ENTRY_W  = KEY_W + HANDLE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_POP    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_POP_RD,
    S_POP_CAP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    search;
    logic    rd_last;
    logic    cap_hit;
    logic    cap_last;
    logic    wr_append;
    logic    wr_move;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_we;
    status_e st;
    logic    out_load;
  } kst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_e mode;
    logic  match;
    logic  not_found;
    logic  cnt_zero;
    logic  cnt_full;
    logic  out_busy;
  } kst_stat_t;

endpackage

/* hw/rtl/kst_ram.sv */
// ----------------------------------------------------------------------------
// kst_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/kst_datapath.sv */
// ----------------------------------------------------------------------------
// kst_datapath
// Request registers, entry count, search pointer, entry RAM and result
// register.
// ----------------------------------------------------------------------------
module kst_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kst_pkg::kst_cmd_t             cmd_i,
  output kst_pkg::kst_stat_t            stat_o,
  input  logic [kst_pkg::MODE_W-1:0]    mode_i,
  input  logic [kst_pkg::KEY_W-1:0]     key_i,
  input  logic [kst_pkg::HANDLE_W-1:0]  handle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kst_pkg::STATUS_W-1:0]  status_o,
  output logic [kst_pkg::HANDLE_W-1:0]  handle_out_o,
  output logic [kst_pkg::KEY_W-1:0]     key_out_o,
  output logic [kst_pkg::COUNT_W-1:0]   count_o,
  output logic                          empty_res_o
);
  import kst_pkg::*;

  mode_e               mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  status_e             status_q;
  logic [KEY_W-1:0]    hit_key_q;
  logic [HANDLE_W-1:0] hit_handle_q;
  logic [ADDR_W-1:0]   pos_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q;
  logic                cmp_valid_q;
  logic [ADDR_W-1:0]   cmp_idx_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [CNT_W-1:0]    out_count_q;

  logic                issue;
  logic [ADDR_W-1:0]   last_addr;
  logic [ADDR_W-1:0]   raddr, waddr;
  logic [ENTRY_W-1:0]  wdata, rdata;
  logic                we;
  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;

  assign rd_key    = rdata[ENTRY_W-1 -: KEY_W];
  assign rd_handle = rdata[HANDLE_W-1:0];
  assign last_addr = ADDR_W'(count_q - CNT_W'(1));
  assign issue     = cmd_i.search && (idx_q < count_q);

  assign raddr = cmd_i.rd_last ? last_addr : idx_q[ADDR_W-1:0];
  assign we    = cmd_i.wr_append || cmd_i.wr_move;
  assign waddr = cmd_i.wr_move ? pos_q : count_q[ADDR_W-1:0];
  assign wdata = cmd_i.wr_move ? rdata : {key_q, handle_q};

  kst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        idx_q       <= '0;
        cmp_valid_q <= 1'b0;
      end else begin
        cmp_valid_q <= issue;
        if (issue) begin
          idx_q <= idx_q + CNT_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q[ADDR_W-1:0];
    if (cmd_i.load) begin
      mode_q       <= mode_e'(mode_i);
      key_q        <= key_i;
      handle_q     <= handle_i;
      status_q     <= ST_OK;
      hit_key_q    <= '0;
      hit_handle_q <= '0;
    end else begin
      if (cmd_i.st_we) begin
        status_q <= cmd_i.st;
      end
      if (cmd_i.cap_hit || cmd_i.cap_last) begin
        hit_key_q    <= rd_key;
        hit_handle_q <= rd_handle;
      end
      if (cmd_i.cap_hit) begin
        pos_q <= cmp_idx_q;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_key_q    <= hit_key_q;
      out_handle_q <= hit_handle_q;
      out_count_q  <= count_q;
    end
  end

  // search exhausted: pointer past the count and no compare pending
  assign stat_o.mode      = mode_q;
  assign stat_o.match     = cmp_valid_q && (rd_key == key_q);
  assign stat_o.not_found = !cmp_valid_q && (idx_q >= count_q);
  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.cnt_full  = (count_q == CNT_W'(CAPACITY));
  assign stat_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign key_out_o    = out_key_q;
  assign handle_out_o = out_handle_q;
  assign count_o      = COUNT_W'(out_count_q);
  assign empty_res_o  = (out_count_q == '0);

endmodule

/* hw/rtl/kst_ctrl.sv */
// ----------------------------------------------------------------------------
// kst_ctrl
// Request sequencer: dispatch, key search, pop, swap-remove, result.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kst_pkg::kst_stat_t  stat_i,
  output kst_pkg::kst_cmd_t   cmd_o
);
  import kst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.st   = ST_OK;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.mode == MODE_POP) begin
          if (stat_i.cnt_zero) begin
            cmd_o.st_we = 1'b1;
            cmd_o.st    = ST_EMPTY;
            state_d     = S_RESULT;
          end else begin
            state_d = S_POP_RD;
          end
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (stat_i.match) begin
          if (stat_i.mode == MODE_ADD) begin
            cmd_o.st_we = 1'b1;
            cmd_o.st    = ST_DUPLICATE;
            state_d     = S_RESULT;
          end else begin
            cmd_o.cap_hit = 1'b1;
            state_d = (stat_i.mode == MODE_REMOVE) ? S_MOVE_RD : S_RESULT;
          end
        end else if (stat_i.not_found) begin
          if (stat_i.mode == MODE_ADD) begin
            if (stat_i.cnt_full) begin
              cmd_o.st_we = 1'b1;
              cmd_o.st    = ST_FULL;
            end else begin
              cmd_o.wr_append = 1'b1;
              cmd_o.cnt_inc   = 1'b1;
            end
          end else begin
            cmd_o.st_we = 1'b1;
            cmd_o.st    = ST_NOT_FOUND;
          end
          state_d = S_RESULT;
        end
      end
      S_POP_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_POP_CAP;
      end
      S_POP_CAP: begin
        cmd_o.cap_last = 1'b1;
        cmd_o.cnt_dec  = 1'b1;
        state_d        = S_RESULT;
      end
      S_MOVE_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        // last entry fills the hole; harmless when the hole is the last slot
        cmd_o.wr_move = 1'b1;
        cmd_o.cnt_dec = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/keyed_set_table.sv */
// Search: add, remove and lookup scan the entries with a pipelined linear
//   search, one entry per cycle; pop reads the last entry without a search, or reports an empty set.
// Throughput: one item at a time; the next item is accepted the cycle after
//   the result is loaded, even while that result still waits downstream.
// Reset: rst_ni clears the controller, the entry count and the result valid;
//   entry storage is not cleared, entries past the count are never read.
// ----------------------------------------------------------------------------
// keyed_set_table
// Fixed-capacity unordered set of key/handle entries with add, pop,
// swap-remove and lookup requests. A sequencer drives a datapath built
// around a single 1R1W entry RAM.
// ----------------------------------------------------------------------------
module keyed_set_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [kst_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [kst_pkg::KEY_W-1:0]    key_i,
  input  logic [kst_pkg::HANDLE_W-1:0]        handle_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kst_pkg::STATUS_W-1:0]        status_o,
  output logic [kst_pkg::HANDLE_W-1:0]        handle_out_o,
  output logic signed [kst_pkg::KEY_W-1:0]    key_out_o,
  output logic [kst_pkg::COUNT_W-1:0]         count_o,
  output logic                                empty_res_o
);
  import kst_pkg::*;

  kst_cmd_t  cmd;
  kst_stat_t stat;

  // Sequencer: one state per phase of a request. The search state keeps
  // one RAM read in flight and compares the previous entry's key.
  kst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Datapath: request latch, count, search pointer, entry RAM and the
  // output register that decouples the result from the next request.
  kst_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .handle_out_o(handle_out_o),
    .key_out_o   (key_out_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o)
  );

`ifndef SYNTH
  // once an item is taken, no second one until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // reported count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

  // an empty status comes only with an empty set and zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |->
      (empty_res_o && key_out_o == '0 && handle_out_o == '0))
    else $error("empty status with non-empty result");

  // a full status only when the set holds capacity entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (count_o == COUNT_W'(CAPACITY)))
    else $error("full status below capacity");
`endif

endmodule
